/* rtl/core/ewpd_pkg.sv */
// Shared types, constants and character tables for the encoded word payload decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ewpd_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic        ModeBase64 = 1'b0;
  localparam logic        ModeQ      = 1'b1;

  localparam logic [7:0]  CharPad        = 8'h3D;
  localparam logic [7:0]  CharUnderscore = 8'h5F;
  localparam logic [7:0]  CharSpace      = 8'h20;

  // Escape phases of Q decoding
  localparam logic [1:0]  EscNone  = 2'd0;
  localparam logic [1:0]  EscEqual = 2'd1;
  localparam logic [1:0]  EscHigh  = 2'd2;

  typedef enum logic [2:0] {
    ErrOk        = 3'd0,
    ErrBadChar   = 3'd1,
    ErrBadLength = 3'd2,
    ErrPadding   = 3'd3,
    ErrBadHex    = 3'd4,
    ErrTruncated = 3'd5
  } err_code_e;

  // Results caused by one character: up to three bytes, first in data[0]
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      last_idx;
    err_code_e       err;
  } bundle_t;

  // Bit 6 set: character is in the Base64 alphabet, bits 5:0 hold its value
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      v = {1'b1, 6'd63};
    end
    return v;
  endfunction

  // Bit 4 set: strict hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return v;
  endfunction

endpackage

/* rtl/core/ewpd_front.sv */
// Front end: accepts characters, keeps the Base64 and Q decoding state and
// classifies each character into a result bundle. Depends on ewpd_pkg.
`timescale 1ns / 1ps

module ewpd_front import ewpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  input  logic       eot_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  logic        mode_q, mode_d;
  logic        drop_q, drop_d;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;
  logic [1:0]  esc_q, esc_d;
  logic [3:0]  hi_q, hi_d;

  logic [6:0]  b64;
  logic [4:0]  hex;
  logic        is_pad;
  logic [1:0]  pad_new;
  logic [23:0] bits_new;
  logic        fail;
  err_code_e   fail_code;

  assign b64      = b64_value(char_i);
  assign hex      = hex_value(char_i);
  assign is_pad   = (char_i == CharPad);
  assign pad_new  = pad_q + {1'b0, is_pad};
  assign bits_new = {bits_q[17:0], (b64[6] ? b64[5:0] : 6'd0)};

  always_comb begin
    mode_d    = mode_q;
    drop_d    = drop_q;
    bits_d    = bits_q;
    pos_d     = pos_q;
    pad_d     = pad_q;
    esc_d     = esc_q;
    hi_d      = hi_q;
    fail      = 1'b0;
    fail_code = ErrOk;
    push_o    = 1'b0;
    bundle_o  = '{data: bits_new, last_idx: 2'd0, err: ErrOk};

    if (accept_i && !drop_q) begin
      if (mode_q == ModeBase64) begin
        if (b64[6]) begin
          if (pad_q != 2'd0) begin
            fail      = 1'b1;
            fail_code = ErrPadding;
          end
        end else if (is_pad) begin
          if (pos_q < 2'd2 && pad_q == 2'd0) begin
            fail      = 1'b1;
            fail_code = ErrPadding;
          end
        end else begin
          fail      = 1'b1;
          fail_code = ErrBadChar;
        end

        if (!fail) begin
          if (pos_q != 2'd3) begin
            if (eot_i) begin
              fail      = 1'b1;
              fail_code = ErrBadLength;
            end else begin
              bits_d = bits_new;
              pos_d  = pos_q + 2'd1;
              pad_d  = pad_new;
            end
          end else if (pad_new != 2'd0 && !eot_i) begin
            fail      = 1'b1;
            fail_code = ErrPadding;
          end else begin
            // Group complete: most significant byte goes out first
            push_o            = 1'b1;
            bundle_o.data[0]  = bits_new[23:16];
            bundle_o.data[1]  = bits_new[15:8];
            bundle_o.data[2]  = bits_new[7:0];
            bundle_o.last_idx = 2'd2 - pad_new;
            bits_d            = '0;
            pos_d             = '0;
            pad_d             = '0;
          end
        end
      end else begin
        case (esc_q)
          EscEqual: begin
            if (eot_i) begin
              fail      = 1'b1;
              fail_code = ErrTruncated;
            end else if (!hex[4]) begin
              fail      = 1'b1;
              fail_code = ErrBadHex;
            end else begin
              hi_d  = hex[3:0];
              esc_d = EscHigh;
            end
          end
          EscHigh: begin
            if (!hex[4]) begin
              fail      = 1'b1;
              fail_code = ErrBadHex;
            end else begin
              push_o           = 1'b1;
              bundle_o.data[0] = {hi_q, hex[3:0]};
              esc_d            = EscNone;
              hi_d             = '0;
            end
          end
          default: begin
            if (is_pad) begin
              if (eot_i) begin
                fail      = 1'b1;
                fail_code = ErrTruncated;
              end else begin
                esc_d = EscEqual;
              end
            end else begin
              push_o           = 1'b1;
              bundle_o.data[0] = (char_i == CharUnderscore) ? CharSpace : char_i;
            end
          end
        endcase
      end

      if (fail) begin
        push_o            = 1'b1;
        bundle_o.data     = '0;
        bundle_o.last_idx = 2'd0;
        bundle_o.err      = fail_code;
        drop_d            = 1'b1;
      end
    end

    // End of text returns every decoding register to its idle value
    if (accept_i && eot_i) begin
      drop_d = 1'b0;
      bits_d = '0;
      pos_d  = '0;
      pad_d  = '0;
      esc_d  = EscNone;
      hi_d   = '0;
    end

    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      drop_d = 1'b0;
      bits_d = '0;
      pos_d  = '0;
      pad_d  = '0;
      esc_d  = EscNone;
      hi_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeBase64;
      drop_q <= 1'b0;
      bits_q <= '0;
      pos_q  <= '0;
      pad_q  <= '0;
      esc_q  <= EscNone;
      hi_q   <= '0;
    end else begin
      mode_q <= mode_d;
      drop_q <= drop_d;
      bits_q <= bits_d;
      pos_q  <= pos_d;
      pad_q  <= pad_d;
      esc_q  <= esc_d;
      hi_q   <= hi_d;
    end
  end

endmodule

/* rtl/core/ewpd_queue.sv */
// Short bundle queue between the front and back ends.
// Depends on ewpd_pkg for the bundle type.
`timescale 1ns / 1ps

module ewpd_queue import ewpd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/ewpd_back.sv */
// Back end: walks the bundle at the head of the queue and hands out one
// result per transaction. Depends on ewpd_pkg.
`timescale 1ns / 1ps

module ewpd_back import ewpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bundle_t    head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output err_code_e  err_o,
  output logic       last_o
);

  logic [1:0] idx_q, idx_d;
  logic       xfer;

  assign valid_o = !empty_i;
  assign byte_o  = head_i.data[idx_q];
  assign err_o   = head_i.err;
  assign last_o  = (idx_q == head_i.last_idx);
  assign xfer    = valid_o && ready_i;
  assign pop_o   = xfer && last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      // Advance within the bundle, rewind once its last result has gone
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* rtl/core/encoded_word_payload_decoder.sv */
// Top level of the encoded word payload decoder (Base64 and Q payloads).
// Depends on ewpd_pkg, ewpd_front, ewpd_queue and ewpd_back.
//
//   Channel   Direction  Handshake               Payload
//   s_axis    in         tvalid / tready         tdata[7:0] in_char, tlast end_of_text
//   m_axis    out        tvalid / tready         tdata[7:0] out_byte, [10:8] error_code,
//                                                tlast last_of_run
//   cfg       in         cfg_we_i                cfg_wdata_i decode_mode
//
// A character is accepted every cycle while the bundle queue has room; the
// front end classifies it in the same cycle. The back end gives one result
// per cycle while the output is ready, so a full Base64 group gives three
// results and the queue absorbs the difference. Reset clears the mode to
// Base64 and empties the queue; a stall on the output holds its result.
`timescale 1ns / 1ps

module encoded_word_payload_decoder import ewpd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, zero above
  output logic        m_axis_tlast    // last_of_run
);

  logic      accept;
  logic      push;
  bundle_t   push_data;
  logic      full;
  logic      empty;
  logic      pop;
  bundle_t   head;
  logic [7:0] out_byte;
  err_code_e out_err;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ewpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .char_i      (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .push_o      (push),
    .bundle_o    (push_data)
  );

  ewpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  ewpd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (out_byte),
    .err_o   (out_err),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_err, out_byte};

endmodule

/* bench/tb_top.sv */
// Self-checking bench for encoded_word_payload_decoder: Base64 and Q payload texts,
// predicted per character and compared result by result on the output stream.
// Depends on ewpd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import ewpd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems = 46;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } char_item_t;

  typedef struct {
    logic [7:0] data;
    err_code_e  err;
    logic       last;
  } decoded_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  char_item_t  char_q[$];
  decoded_t    decoded_q[$];
  logic [7:0]  text_buf[$];

  // decoder state as predicted
  logic        mode_r;
  logic [23:0] grp_bits;
  int          grp_pos;
  int          pad_cnt;
  logic [1:0]  esc_phase;
  logic [3:0]  hi_nib;
  bit          drop_st;

  bit          s_busy;
  bit          calm;
  int          s_gap_left;
  int          m_gap_left;
  int          items_sent;
  int          mismatches;
  int          cycle_cnt;

  encoded_word_payload_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int b64_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit lower);
    if (v < 10) return 8'("0" + v);
    return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  task automatic clear_decode();
    grp_bits  = '0;
    grp_pos   = 0;
    pad_cnt   = 0;
    esc_phase = EscNone;
    hi_nib    = '0;
    drop_st   = 1'b0;
  endtask

  // Work out the results one accepted character causes and queue them.
  task automatic decode_char(input logic [7:0] ch, input logic eot);
    logic [7:0] outs [3];
    int         n;
    int         v;
    err_code_e  err;
    n = 0;
    err = ErrOk;
    if (drop_st) begin
      if (eot) clear_decode();
      return;
    end
    if (mode_r == ModeBase64) begin
      v = b64_index(ch);
      if (v >= 0) begin
        if (pad_cnt != 0) err = ErrPadding;
        else grp_bits = {grp_bits[17:0], 6'(v)};
      end else if (ch == CharPad) begin
        if (grp_pos < 2 && pad_cnt == 0) begin
          err = ErrPadding;
        end else begin
          grp_bits = {grp_bits[17:0], 6'd0};
          pad_cnt++;
        end
      end else begin
        err = ErrBadChar;
      end
      if (err == ErrOk) begin
        grp_pos++;
        if (grp_pos < 4) begin
          if (eot) err = ErrBadLength;
        end else if (pad_cnt != 0 && !eot) begin
          err = ErrPadding;
        end else begin
          n = 3 - pad_cnt;
          outs[0] = grp_bits[23:16];
          outs[1] = grp_bits[15:8];
          outs[2] = grp_bits[7:0];
          grp_bits = '0;
          grp_pos = 0;
          pad_cnt = 0;
        end
      end
    end else if (esc_phase == EscNone) begin
      if (ch == CharPad) begin
        if (eot) err = ErrTruncated;
        else esc_phase = EscEqual;
      end else begin
        outs[0] = (ch == CharUnderscore) ? CharSpace : ch;
        n = 1;
      end
    end else if (esc_phase == EscEqual) begin
      v = hex_digit(ch);
      if (eot) begin
        err = ErrTruncated;
      end else if (v < 0) begin
        err = ErrBadHex;
      end else begin
        hi_nib = 4'(v);
        esc_phase = EscHigh;
      end
    end else begin
      v = hex_digit(ch);
      if (v < 0) begin
        err = ErrBadHex;
      end else begin
        outs[0] = {hi_nib, 4'(v)};
        n = 1;
        esc_phase = EscNone;
        hi_nib = '0;
      end
    end
    if (err != ErrOk) begin
      outs[0] = '0;
      n = 1;
      drop_st = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      decoded_q.push_back('{data: outs[k], err: err, last: (k == n - 1)});
    end
    if (eot) clear_decode();
  endtask

  task automatic push_char(input logic [7:0] ch, input logic eot);
    char_q.push_back('{ch: ch, eot: eot});
    items_sent++;
  endtask

  task automatic push_str(input string s, input logic eot_at_end);
    for (int i = 0; i < s.len(); i++) push_char(s[i], eot_at_end && (i == s.len() - 1));
  endtask

  task automatic push_text(input logic eot_at_end);
    for (int i = 0; i < text_buf.size(); i++) begin
      push_char(text_buf[i], eot_at_end && (i == text_buf.size() - 1));
    end
  endtask

  task automatic make_b64_text();
    int groups;
    int pads;
    text_buf.delete();
    groups = $urandom_range(1, 3);
    pads = $urandom_range(0, 2);
    for (int g = 0; g < groups; g++) begin
      for (int i = 0; i < 4; i++) begin
        if (g == groups - 1 && i >= 4 - pads) text_buf.push_back(CharPad);
        else text_buf.push_back(b64_char($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic make_q_text();
    int         tokens;
    int         kind;
    logic [7:0] ch;
    text_buf.delete();
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 5);
      if (kind == 0) begin
        text_buf.push_back(CharUnderscore);
      end else if (kind <= 2) begin
        text_buf.push_back(CharPad);
        text_buf.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
        text_buf.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
      end else begin
        ch = 8'($urandom_range(0, 255));
        text_buf.push_back((ch == CharPad) ? CharUnderscore : ch);
      end
    end
  endtask

  task automatic make_text();
    if (mode_r == ModeBase64) make_b64_text();
    else make_q_text();
  endtask

  // Mostly well-formed texts; some corrupted or cut short, some plain noise.
  task automatic run_random_phase(input int target);
    int first;
    int kind;
    int cut;
    first = items_sent;
    while (items_sent - first < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)),
                                                 $urandom_range(0, 7) == 0);
      end else begin
        make_text();
        if (kind >= 7) begin
          cut = $urandom_range(0, 2);
          if (cut != 1) text_buf[$urandom_range(0, text_buf.size() - 1)] =
                          8'($urandom_range(0, 255));
          if (cut != 0) begin
            cut = $urandom_range(1, text_buf.size());
            while (text_buf.size() > cut) void'(text_buf.pop_back());
          end
        end
        push_text(1'b1);
      end
    end
    // leave a text open so the next mode write lands mid-text
    if ($urandom_range(0, 1) == 1) begin
      make_text();
      push_text(1'b0);
    end
  endtask

  task automatic wait_idle();
    while (char_q.size() != 0 || s_busy || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    mode_r = mode;
    clear_decode();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Input driver: hold a presented transaction until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !s_busy) begin
      if (s_gap_left > 0) begin
        s_gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (char_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        s_gap_left = $urandom_range(0, 7);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= char_q[0].ch;
        s_axis_tlast <= char_q[0].eot;
        s_busy = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (m_gap_left > 0) begin
      m_gap_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_gap_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predict on input transactions first, then check output transactions.
  always @(posedge clk_i) begin : monitor
    decoded_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      decode_char(s_axis_tdata, s_axis_tlast);
      void'(char_q.pop_front());
      s_busy = 1'b0;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[10:8] !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, m_axis_tdata[10:8]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    s_busy = 1'b0;
    calm = 1'b0;
    s_gap_left = 0;
    m_gap_left = 0;
    items_sent = 0;
    mismatches = 0;
    cycle_cnt = 0;
    mode_r = ModeBase64;
    clear_decode();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(ModeBase64);
    push_str("/+9zTQ==", 1'b1);   // full group then a single-byte group
    push_char(CharPad, 1'b1);     // padding at the start of a group
    push_char(8'h00, 1'b1);       // NUL is not in the alphabet
    push_str("A", 1'b1);          // incomplete group at end of text
    push_str("AB=A", 1'b1);       // data after padding
    push_str("QQ==", 1'b0);       // padded group that is not last
    push_str("x", 1'b1);
    wait_idle();

    write_mode(ModeQ);
    push_str("_=4f", 1'b0);
    push_char(8'hFF, 1'b1);
    push_str("=4g", 1'b1);        // bad second hex digit
    push_str("=4", 1'b1);         // escape cut short

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) write_mode(ModeBase64);
      else if (ph == 1) write_mode(ModeQ);
      else write_mode(1'($urandom_range(0, 1)));
      if (ph == 7) calm = 1'b1;
      run_random_phase(PhaseItems);
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ewpd_pkg.sv
rtl/core/ewpd_front.sv
rtl/core/ewpd_queue.sv
rtl/core/ewpd_back.sv
rtl/core/encoded_word_payload_decoder.sv
bench/tb_top.sv
